// ===== rtl/core/utc_pkg.sv =====
package utc_pkg;

  // Surrogate prefixes on the top six bits of a code unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // Base of the supplementary planes
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Code point limits for the UTF-8 length classes
  localparam logic [20:0] LIMIT_ONE   = 21'h00080;
  localparam logic [20:0] LIMIT_TWO   = 21'h00800;
  localparam logic [20:0] LIMIT_THREE = 21'h10000;

  // UTF-8 lead and continuation prefixes
  localparam logic [2:0] LEAD_TWO   = 3'b110;
  localparam logic [3:0] LEAD_THREE = 4'b1110;
  localparam logic [4:0] LEAD_FOUR  = 5'b11110;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  // One queued job: a code point to encode, or a bare end marker
  typedef struct packed {
    logic [20:0] cp;
    logic        has_cp;
    logic        eos;
  } entry_t;

  // Request from the front part into the queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

// ===== rtl/core/utc_in_if.sv =====
interface utc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/utc_out_if.sv =====
interface utc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;

  modport source (output valid, output out_byte, output byte_valid, output end_of_string,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_string,
                  output ready);
endinterface

// ===== rtl/core/utc_front.sv =====
module utc_front (
  input  logic           clk,
  input  logic           rst,
  utc_in_if.sink         in_ch,
  output utc_pkg::push_t push,
  input  logic           push_ready
);

  logic                half;
  logic [7:0]          low_byte;
  logic                hs_held;
  logic [9:0]          hs_bits;
  logic                pend_valid;
  utc_pkg::entry_t     pend_entry;

  logic                accept;
  logic [15:0]         unit;
  logic                unit_hi;
  logic                unit_lo;
  logic                c_pair;
  logic                c_old;
  logic                hold_new;
  logic                c_flush;
  logic                c_plain;
  logic                first_v;
  logic                second_v;
  logic [20:0]         first_cp;
  logic [20:0]         second_cp;
  logic                slot_a_v;
  logic                slot_b_v;
  utc_pkg::entry_t     slot_a;
  utc_pkg::entry_t     slot_b;

  // Take a byte only when the spare slot is empty and the queue has room
  assign in_ch.ready = !pend_valid && push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the unit formed by this byte and the held low byte
  always_comb begin
    unit     = {in_ch.in_byte, low_byte};
    unit_hi  = (unit[15:10] == utc_pkg::HIGH_SURR_TAG);
    unit_lo  = (unit[15:10] == utc_pkg::LOW_SURR_TAG);
    c_pair   = half && hs_held && unit_lo;
    c_old    = hs_held && !(half && unit_lo) && (half || in_ch.last_byte);
    hold_new = half && unit_hi;
    c_flush  = hold_new && in_ch.last_byte;
    c_plain  = half && !unit_hi && !c_pair && (unit != 16'h0000);
    first_v  = c_pair || c_old;
    second_v = c_flush || c_plain;
    first_cp = c_pair ? (utc_pkg::SUPP_BASE + {1'b0, hs_bits, unit[9:0]})
                      : {5'd0, utc_pkg::HIGH_SURR_TAG, hs_bits};
    second_cp = {5'd0, unit};
  end

  // Order the code points into at most two queue entries
  always_comb begin
    slot_a_v      = first_v || second_v || in_ch.last_byte;
    slot_b_v      = first_v && second_v;
    slot_a.cp     = first_v ? first_cp : second_cp;
    slot_a.has_cp = first_v || second_v;
    slot_a.eos    = in_ch.last_byte && !slot_b_v;
    slot_b.cp     = second_cp;
    slot_b.has_cp = 1'b1;
    slot_b.eos    = in_ch.last_byte;
  end

  // Drive the queue: the spare entry goes first
  always_comb begin
    if (pend_valid) begin
      push.valid = 1'b1;
      push.entry = pend_entry;
    end else begin
      push.valid = accept && slot_a_v;
      push.entry = slot_a;
    end
  end

  // Update pairing and surrogate state
  always_ff @(posedge clk) begin
    if (rst) begin
      half       <= 1'b0;
      low_byte   <= 8'd0;
      hs_held    <= 1'b0;
      hs_bits    <= 10'd0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && push_ready) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (slot_b_v) begin
          pend_valid <= 1'b1;
          pend_entry <= slot_b;
        end
        if (in_ch.last_byte) begin
          half     <= 1'b0;
          low_byte <= 8'd0;
          hs_held  <= 1'b0;
          hs_bits  <= 10'd0;
        end else if (half) begin
          half    <= 1'b0;
          hs_held <= hold_new;
          if (hold_new) begin
            hs_bits <= unit[9:0];
          end
        end else begin
          half     <= 1'b1;
          low_byte <= in_ch.in_byte;
        end
      end
    end
  end

endmodule

// ===== rtl/core/utc_queue.sv =====
module utc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  utc_pkg::push_t  push,
  output logic            push_ready,
  output logic            head_valid,
  output utc_pkg::entry_t head,
  input  logic            pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utc_pkg::entry_t store [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/utc_back.sv =====
module utc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  utc_pkg::entry_t head,
  output logic            pop,
  utc_out_if.source       out_ch
);

  logic [1:0]      idx;
  logic            out_valid;
  logic [7:0]      out_byte;
  logic            byte_valid;
  logic            end_of_string;

  logic [1:0]      n_m1;
  logic [3:0][7:0] bytes;
  logic            load;
  logic            last_of;

  // Encode the head code point into its UTF-8 bytes
  always_comb begin
    bytes = '0;
    if (!head.has_cp) begin
      n_m1 = 2'd0;
    end else if (head.cp < utc_pkg::LIMIT_ONE) begin
      n_m1     = 2'd0;
      bytes[0] = {1'b0, head.cp[6:0]};
    end else if (head.cp < utc_pkg::LIMIT_TWO) begin
      n_m1     = 2'd1;
      bytes[0] = {utc_pkg::LEAD_TWO, head.cp[10:6]};
      bytes[1] = {utc_pkg::CONT_TAG, head.cp[5:0]};
    end else if (head.cp < utc_pkg::LIMIT_THREE) begin
      n_m1     = 2'd2;
      bytes[0] = {utc_pkg::LEAD_THREE, head.cp[15:12]};
      bytes[1] = {utc_pkg::CONT_TAG, head.cp[11:6]};
      bytes[2] = {utc_pkg::CONT_TAG, head.cp[5:0]};
    end else begin
      n_m1     = 2'd3;
      bytes[0] = {utc_pkg::LEAD_FOUR, head.cp[20:18]};
      bytes[1] = {utc_pkg::CONT_TAG, head.cp[17:12]};
      bytes[2] = {utc_pkg::CONT_TAG, head.cp[11:6]};
      bytes[3] = {utc_pkg::CONT_TAG, head.cp[5:0]};
    end
  end

  // Load the output register whenever it is empty or being drained
  assign load    = head_valid && (!out_valid || out_ch.ready);
  assign last_of = (idx == n_m1);
  assign pop     = load && last_of;

  assign out_ch.valid         = out_valid;
  assign out_ch.out_byte      = out_byte;
  assign out_ch.byte_valid    = byte_valid;
  assign out_ch.end_of_string = end_of_string;

  // Step through the bytes of the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_of ? 2'd0 : idx + 2'd1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= bytes[idx];
      byte_valid    <= head.has_cp;
      end_of_string <= head.eos && last_of;
    end
  end

endmodule

// ===== rtl/core/utf16le_to_utf8_transcoder.sv =====
// UTF-16LE to UTF-8 transcoder.
// in_ch carries the string one byte per request, low byte of each code unit
// first, with last_byte set on the final byte. out_ch carries one UTF-8 byte
// per request; byte_valid is low only on a bare end marker, and end_of_string
// flags the final result of a string. Both channels use valid/ready.
// The front part pairs bytes into units, joins surrogate pairs and queues one
// entry per cycle while the queue has room; the back part encodes the head code
// point and emits one byte per cycle into a registered output stage while the
// receiver is ready. The first byte of a code point passes from the request
// completing it through the queue store and then the output register before it
// is offered on out_ch, and is held there until the output side is ready.
// Throughput: in_ch takes a byte every cycle while the queue has room, except
// that a byte yielding two code points (a flushed high surrogate plus another)
// holds in_ch.ready low while the second one is queued. The sustained rate is
// set by the output port at one UTF-8 byte per cycle.
// Reset clears the pairing state, empties the queue and drops any result in
// flight. When the receiver stalls, the output holds, the queue fills and
// in_ch.ready falls once QUEUE_DEPTH entries are waiting.
module utf16le_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  utc_in_if.sink    in_ch,
  utc_out_if.source out_ch
);

  utc_pkg::push_t  push;
  logic            push_ready;
  logic            head_valid;
  utc_pkg::entry_t head;
  logic            pop;

  utc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  utc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  utc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
